[src/frkc_pkg.sv]
// ----------------------------------------------------------------------------
// frkc_pkg
// Shared constants, codes and types of the FIFO-replacement keyed cache.
// ----------------------------------------------------------------------------
package frkc_pkg;

  localparam int FRKC_DEPTH    = 16;
  localparam int FRKC_KEY_BITS = 32;
  localparam int FRKC_FIELD_W  = 32;
  localparam int FRKC_CNT_W    = 5;
  localparam int FRKC_CAP_W    = 5;

  localparam logic [FRKC_CAP_W-1:0] FRKC_CAP_RESET = 5'd10;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NULL_KEY = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EVICT,
    ST_APPEND,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                    hit;
    logic [FRKC_FIELD_W-1:0] value_out;
    status_t                 status;
    logic                    evicted;
    logic [FRKC_FIELD_W-1:0] evicted_key;
    logic [FRKC_CNT_W-1:0]   entry_count;
    logic                    is_empty;
  } result_t;

endpackage

[src/frkc_mem.sv]
// ----------------------------------------------------------------------------
// frkc_mem
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frkc_mem #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

[src/frkc_ctrl.sv]
// ----------------------------------------------------------------------------
// frkc_ctrl
// Sequencer of the cache: scans the entry ring with one shared key comparator,
// appends, evicts at the head and closes gaps one entry at a time.
// ----------------------------------------------------------------------------
module frkc_ctrl #(
  parameter int DEPTH    = 16,
  parameter int KW       = 32,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [frkc_pkg::FRKC_FIELD_W-1:0] in_key,
  input  logic [frkc_pkg::FRKC_FIELD_W-1:0] in_value,
  input  logic [frkc_pkg::FRKC_CAP_W-1:0]   capacity,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic [KW+frkc_pkg::FRKC_FIELD_W-1:0] mem_wdata,
  output logic [AW-1:0]                     mem_raddr,
  input  logic [KW+frkc_pkg::FRKC_FIELD_W-1:0] mem_rdata,
  output logic                              out_valid,
  input  logic                              out_stall,
  output frkc_pkg::result_t                 out_res
);

  import frkc_pkg::*;

  localparam int FW = FRKC_FIELD_W;
  localparam int EW = (CW > FRKC_CAP_W) ? CW : FRKC_CAP_W;
  localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t             state_r, state_nxt;
  action_t            action_r, action_nxt;
  logic [KW-1:0]      key_r, key_nxt;
  logic [FW-1:0]      value_r, value_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [KW-1:0]      first_key_r, first_key_nxt;
  logic               hit_r, hit_nxt;
  logic [FW-1:0]      val_r, val_nxt;
  status_t            status_r, status_nxt;
  logic               evicted_r, evicted_nxt;
  logic [KW-1:0]      evkey_r, evkey_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r, out_nxt;

  logic [KW-1:0]      rkey;
  logic [FW-1:0]      rval;
  logic               match;
  logic               last;
  logic               shift_last;
  logic               full;
  logic               null_key;
  logic               out_free;
  logic [EW-1:0]      cap_e;
  logic [EW-1:0]      ecap;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign rkey       = mem_rdata[KW+FW-1:FW];
  assign rval       = mem_rdata[FW-1:0];
  assign match      = (rkey == key_r);
  assign last       = ((CW'(idx_r) + CW'(1)) == occ_r);
  assign shift_last = ((CW'(idx_r) + CW'(2)) == occ_r);
  assign null_key   = (key_r == '0);
  assign out_free   = !out_valid_r || !out_stall;
  assign cap_e      = EW'(capacity);
  assign ecap       = (cap_e == '0) ? EW'(1) : ((cap_e > DEPTH_E) ? DEPTH_E : cap_e);
  assign full       = (EW'(occ_r) >= ecap);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (action_r == ACT_CLEAR || null_key) begin
          state_nxt = ST_DONE;
        end else if (occ_r != '0) begin
          state_nxt = ST_SCAN_RD;
        end else if (action_r == ACT_INSERT) begin
          state_nxt = ST_APPEND;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (match) begin
          if (action_r == ACT_REMOVE && !last) begin
            state_nxt = ST_SHIFT_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end else if (last) begin
          if (action_r == ACT_INSERT) begin
            state_nxt = full ? ST_EVICT : ST_APPEND;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_EVICT: begin
        state_nxt = ST_APPEND;
      end
      ST_APPEND: begin
        state_nxt = ST_DONE;
      end
      ST_SHIFT_RD: begin
        state_nxt = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        state_nxt = shift_last ? ST_DONE : ST_SHIFT_RD;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    action_nxt    = action_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    first_key_nxt = first_key_r;
    hit_nxt       = hit_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    evicted_nxt   = evicted_r;
    evkey_nxt     = evkey_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = phys(head_r, idx_r);
    mem_wdata     = {key_r, value_r};
    mem_raddr     = phys(head_r, idx_r);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          action_nxt  = action_t'(in_action);
          key_nxt     = in_key[KW-1:0];
          value_nxt   = in_value;
          idx_nxt     = '0;
          hit_nxt     = 1'b0;
          val_nxt     = '0;
          status_nxt  = STS_OK;
          evicted_nxt = 1'b0;
          evkey_nxt   = '0;
        end
      end
      ST_START: begin
        if (action_r == ACT_CLEAR) begin
          occ_nxt  = '0;
          head_nxt = '0;
        end else if (null_key) begin
          status_nxt = STS_NULL_KEY;
        end else if (occ_r == '0 && action_r == ACT_REMOVE) begin
          status_nxt = STS_NOT_FOUND;
        end
      end
      ST_SCAN_RD: begin
        mem_raddr = phys(head_r, idx_r);
      end
      ST_SCAN_CMP: begin
        if (idx_r == '0) begin
          first_key_nxt = rkey;
        end
        if (match) begin
          hit_nxt = 1'b1;
          case (action_r)
            ACT_LOOKUP: begin
              val_nxt = rval;
            end
            ACT_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = phys(head_r, idx_r);
            end
            default: begin
              if (last) begin
                occ_nxt = occ_r - CW'(1);
              end
            end
          endcase
        end else if (last) begin
          if (action_r == ACT_REMOVE) begin
            status_nxt = STS_NOT_FOUND;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_EVICT: begin
        evicted_nxt = 1'b1;
        evkey_nxt   = first_key_r;
        head_nxt    = phys(head_r, AW'(1));
        occ_nxt     = occ_r - CW'(1);
      end
      ST_APPEND: begin
        if (occ_r < DEPTH_C) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_r, occ_r[AW-1:0]);
          occ_nxt   = occ_r + CW'(1);
        end
      end
      ST_SHIFT_RD: begin
        mem_raddr = phys(head_r, idx_r + AW'(1));
      end
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head_r, idx_r);
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r + AW'(1);
        if (shift_last) begin
          occ_nxt = occ_r - CW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.hit         = hit_r;
          out_nxt.value_out   = val_r;
          out_nxt.status      = status_r;
          out_nxt.evicted     = evicted_r;
          out_nxt.evicted_key = FW'(evkey_r);
          out_nxt.entry_count = FRKC_CNT_W'(occ_r);
          out_nxt.is_empty    = (occ_r == '0);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r    <= action_nxt;
    key_r       <= key_nxt;
    value_r     <= value_nxt;
    idx_r       <= idx_nxt;
    first_key_r <= first_key_nxt;
    hit_r       <= hit_nxt;
    val_r       <= val_nxt;
    status_r    <= status_nxt;
    evicted_r   <= evicted_nxt;
    evkey_r     <= evkey_nxt;
    out_r       <= out_nxt;
  end

endmodule

[src/fifo_replacement_keyed_cache.sv]
// ----------------------------------------------------------------------------
// fifo_replacement_keyed_cache
// Keyed cache in insertion order with oldest-first eviction, lookup, update,
// remove with compaction and clear, over a ring of entries in one memory.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   in_       in_valid / in_stall  in_action, in_key, in_value
//   out_      out_valid / out_stall hit, value_out, status, evicted,
//                                  evicted_key, entry_count, is_empty
//   cfg_      cfg_valid / cfg_ready cfg_capacity
//
// Clear and a null key skip the key scan. Other items scan the stored entries
// one by one up to a match or the last entry; a remove then moves each younger
// entry down one place. The single memory port pair sets the scan and shift
// pace. The result register lets a new item be taken while a result waits
// under out_stall. Reset is synchronous and empties the cache.
//
module fifo_replacement_keyed_cache #(
  parameter int DEPTH    = frkc_pkg::FRKC_DEPTH,
  parameter int KEY_BITS = frkc_pkg::FRKC_KEY_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic [frkc_pkg::FRKC_FIELD_W-1:0]   in_key,
  input  logic [frkc_pkg::FRKC_FIELD_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic [frkc_pkg::FRKC_FIELD_W-1:0]   out_value_out,
  output logic [1:0]                          out_status,
  output logic                                out_evicted,
  output logic [frkc_pkg::FRKC_FIELD_W-1:0]   out_evicted_key,
  output logic [frkc_pkg::FRKC_CNT_W-1:0]     out_entry_count,
  output logic                                out_is_empty,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [frkc_pkg::FRKC_CAP_W-1:0]     cfg_capacity
);

  import frkc_pkg::*;

  localparam int KW = (KEY_BITS < FRKC_FIELD_W) ? KEY_BITS : FRKC_FIELD_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = KW + FRKC_FIELD_W;

  logic [FRKC_CAP_W-1:0] capacity_r, capacity_nxt;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [MW-1:0]         mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [MW-1:0]         mem_rdata;
  result_t               res;

  assign cfg_ready    = 1'b1;
  assign capacity_nxt = (cfg_valid && cfg_ready) ? cfg_capacity : capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= FRKC_CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  frkc_mem #(
    .WIDTH (MW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  frkc_ctrl #(
    .DEPTH    (DEPTH),
    .KW       (KW),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_key    (in_key),
    .in_value  (in_value),
    .capacity  (capacity_r),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_hit         = res.hit;
  assign out_value_out   = res.value_out;
  assign out_status      = res.status;
  assign out_evicted     = res.evicted;
  assign out_evicted_key = res.evicted_key;
  assign out_entry_count = res.entry_count;
  assign out_is_empty    = res.is_empty;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the FIFO-replacement keyed cache. A short table
// of directed operations covers the empty cache, null keys, updates, eviction
// at the reset capacity, removal at both ends and in the middle, and clear.
// Random phases then run at several capacity settings, including the extremes
// and a capacity lowered below the current count. Every result is compared
// field by field with a predictor kept in the testbench, under random idle
// gaps on the input and random stalls on the result channel.
// ----------------------------------------------------------------------------
module tb_top;
  import frkc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE   = 40;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 90;

  typedef struct {
    action_t     act;
    logic [31:0] key;
    logic [31:0] val;
    bit          typed;
    result_t     res;
  } op_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic        out_hit;
  logic [31:0] out_value_out;
  logic [1:0]  out_status;
  logic        out_evicted;
  logic [31:0] out_evicted_key;
  logic [4:0]  out_entry_count;
  logic        out_is_empty;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_capacity;

  logic [31:0] cached_keys [FRKC_DEPTH];
  logic [31:0] cached_vals [FRKC_DEPTH];
  int          cached_count;
  int          capacity_reg;

  result_t     pending_results [$];
  op_row_t     directed_ops [$];
  logic [31:0] key_pool [POOL_SIZE];
  int          error_count;
  int          results_seen;
  int          cycle_count;
  bit          tx_quiet;
  bit          rx_quiet;

  fifo_replacement_keyed_cache u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_value_out  (out_value_out),
    .out_status     (out_status),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .out_entry_count(out_entry_count),
    .out_is_empty   (out_is_empty),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int usable_capacity(input int cap);
    if (cap == 0) return 1;
    if (cap > FRKC_DEPTH) return FRKC_DEPTH;
    return cap;
  endfunction

  function automatic void drop_entry(input int pos);
    int i;
    for (i = pos; i + 1 < cached_count; i++) begin
      cached_keys[i] = cached_keys[i + 1];
      cached_vals[i] = cached_vals[i + 1];
    end
    cached_count--;
  endfunction

  function automatic result_t apply_cache_op(input logic [1:0] act, input logic [31:0] key,
                                             input logic [31:0] val);
    result_t r;
    int      pos;
    int      i;
    r = '0;
    pos = -1;
    if (act == ACT_CLEAR) begin
      cached_count = 0;
    end else if (key == 32'd0) begin
      r.status = STS_NULL_KEY;
    end else begin
      for (i = 0; i < cached_count; i++) begin
        if (pos < 0 && cached_keys[i] == key) pos = i;
      end
      r.hit = (pos >= 0);
      if (act == ACT_LOOKUP) begin
        if (pos >= 0) r.value_out = cached_vals[pos];
      end else if (act == ACT_INSERT) begin
        if (pos >= 0) begin
          cached_vals[pos] = val;
        end else begin
          if (cached_count >= usable_capacity(capacity_reg) && cached_count > 0) begin
            r.evicted = 1'b1;
            r.evicted_key = cached_keys[0];
            drop_entry(0);
          end
          if (cached_count < FRKC_DEPTH) begin
            cached_keys[cached_count] = key;
            cached_vals[cached_count] = val;
            cached_count++;
          end
        end
      end else begin
        if (pos >= 0) drop_entry(pos);
        else r.status = STS_NOT_FOUND;
      end
    end
    r.entry_count = cached_count[4:0];
    r.is_empty = (cached_count == 0);
    return r;
  endfunction

  function automatic int idle_len(input bit quiet);
    int roll;
    roll = $urandom_range(99);
    if (quiet || roll < 70) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(10, 4);
    return $urandom_range(50, 20);
  endfunction

  function automatic void add_row(input action_t act, input logic [31:0] key,
                                  input logic [31:0] val);
    op_row_t row;
    row.act = act;
    row.key = key;
    row.val = val;
    row.typed = 1'b0;
    row.res = '0;
    directed_ops = {directed_ops, row};
  endfunction

  function automatic void add_typed(input action_t act, input logic [31:0] key,
                                    input logic [31:0] val, input logic hit,
                                    input logic [31:0] vout, input status_t st,
                                    input logic ev, input logic [31:0] ekey,
                                    input logic [4:0] cnt);
    op_row_t row;
    row.act = act;
    row.key = key;
    row.val = val;
    row.typed = 1'b1;
    row.res.hit = hit;
    row.res.value_out = vout;
    row.res.status = st;
    row.res.evicted = ev;
    row.res.evicted_key = ekey;
    row.res.entry_count = cnt;
    row.res.is_empty = (cnt == 5'd0);
    directed_ops = {directed_ops, row};
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    error_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("transfer with nothing pending", 1, 0);
    end else begin
      want = pending_results.pop_front();
      if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
      if (out_value_out !== want.value_out)
        report_mismatch("value_out", out_value_out, want.value_out);
      if (out_status !== want.status) report_mismatch("status", out_status, want.status);
      if (out_evicted !== want.evicted) report_mismatch("evicted", out_evicted, want.evicted);
      if (out_evicted_key !== want.evicted_key)
        report_mismatch("evicted_key", out_evicted_key, want.evicted_key);
      if (out_entry_count !== want.entry_count)
        report_mismatch("entry_count", out_entry_count, want.entry_count);
      if (out_is_empty !== want.is_empty)
        report_mismatch("is_empty", out_is_empty, want.is_empty);
    end
    results_seen++;
  endtask

  task automatic offer_item(input action_t act, input logic [31:0] key, input logic [31:0] val,
                            input bit typed, input result_t typed_res);
    int      gap;
    result_t predicted;
    gap = idle_len(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_key    <= key;
    in_value  <= val;
    predicted = apply_cache_op(act, key, val);
    if (typed) predicted = typed_res;
    pending_results = {pending_results, predicted};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(input int cap);
    cfg_valid    <= 1'b1;
    cfg_capacity <= cap[4:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    capacity_reg = cap;
  endtask

  task automatic random_item(input int pool_n);
    action_t     act;
    logic [31:0] key;
    int          roll;
    roll = $urandom_range(99);
    if (roll < 2) act = ACT_CLEAR;
    else if (roll < 38) act = ACT_LOOKUP;
    else if (roll < 75) act = ACT_INSERT;
    else act = ACT_REMOVE;
    roll = $urandom_range(99);
    if (roll < 4) key = 32'd0;
    else if (roll < 9) key = $urandom;
    else key = key_pool[$urandom_range(pool_n - 1)];
    offer_item(act, key, $urandom, 1'b0, '0);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_result();
        if (results_seen == 150 || results_seen == 450) stall_left = 300;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_len(rx_quiet);
      end
    end
  end

  initial begin
    int i;
    int ph;
    int n;
    int pool_n;
    int phase_cap [NUM_PHASES];
    bit phase_clear [NUM_PHASES];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_LOOKUP;
    in_key = '0;
    in_value = '0;
    cfg_valid = 1'b0;
    cfg_capacity = '0;
    cycle_count = 0;
    error_count = 0;
    results_seen = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    cached_count = 0;
    capacity_reg = FRKC_CAP_RESET;
    for (i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == 32'd0) key_pool[i] = 32'd1;
    end
    phase_cap = '{16, 1, 0, 31, 3, 17, 10, 0};
    phase_cap[NUM_PHASES - 1] = $urandom_range(31);
    phase_clear = '{1, 1, 1, 1, 0, 1, 0, 1};

    add_typed(ACT_LOOKUP, 32'd5, 32'hDEAD_BEEF, 0, 0, STS_OK, 0, 0, 0);
    add_typed(ACT_REMOVE, 32'd5, 32'd0, 0, 0, STS_NOT_FOUND, 0, 0, 0);
    add_typed(ACT_INSERT, 32'd0, 32'hFFFF_FFFF, 0, 0, STS_NULL_KEY, 0, 0, 0);
    add_typed(ACT_LOOKUP, 32'd0, 32'd0, 0, 0, STS_NULL_KEY, 0, 0, 0);
    add_typed(ACT_REMOVE, 32'd0, 32'd0, 0, 0, STS_NULL_KEY, 0, 0, 0);
    add_typed(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, STS_OK, 0, 0, 1);
    add_typed(ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1, 32'hFFFF_FFFF, STS_OK, 0, 0, 1);
    add_typed(ACT_INSERT, 32'd1, 32'd0, 0, 0, STS_OK, 0, 0, 2);
    add_typed(ACT_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1, 0, STS_OK, 0, 0, 2);
    add_typed(ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1, 32'hA5A5_A5A5, STS_OK, 0, 0, 2);
    for (i = 2; i <= 9; i++) add_row(ACT_INSERT, i, i * 32'h0101_0101);
    add_typed(ACT_INSERT, 32'd10, 32'h5A5A_5A5A, 0, 0, STS_OK, 1, 32'hFFFF_FFFF, 10);
    add_row(ACT_REMOVE, 32'd5, 32'd0);
    add_row(ACT_REMOVE, 32'd1, 32'd0);
    add_row(ACT_REMOVE, 32'd10, 32'd0);
    add_row(ACT_LOOKUP, 32'd7, 32'd0);
    add_typed(ACT_CLEAR, 32'h1234_5678, 32'd0, 0, 0, STS_OK, 0, 0, 0);
    add_typed(ACT_LOOKUP, 32'd1, 32'd0, 0, 0, STS_OK, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_ops[i]) begin
      offer_item(directed_ops[i].act, directed_ops[i].key, directed_ops[i].val,
                 directed_ops[i].typed, directed_ops[i].res);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      if (phase_clear[ph]) begin
        offer_item(ACT_CLEAR, $urandom, $urandom, 1'b0, '0);
        drain_results();
      end
      write_capacity(phase_cap[ph]);
      tx_quiet = (ph == 2) || (ph == 6);
      rx_quiet = (ph == 4) || (ph == 6);
      pool_n = usable_capacity(phase_cap[ph]) + 1 + $urandom_range(5);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 40) drain_results();
        random_item(pool_n);
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[fifo_replacement_keyed_cache.f]
src/frkc_pkg.sv
src/frkc_mem.sv
src/frkc_ctrl.sv
src/fifo_replacement_keyed_cache.sv
dv/tb_top.sv
